/* rtl/websocket_frame_unmasker_assert.svh */
// Assertion macros for the frame unmasker checker.
`ifndef WEBSOCKET_FRAME_UNMASKER_ASSERT_SVH
`define WEBSOCKET_FRAME_UNMASKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSFU_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("wsfu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSFU_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("wsfu assertion failed");

`endif

/* rtl/wsfu_pkg.sv */
// Types and constants for the websocket frame unmasker.
`timescale 1ns / 1ps
`default_nettype none
package wsfu_pkg;

  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [6:0] LEN_MAX   = 7'd125;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_CLOSE   = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_KEY     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DROP    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       last_of_message;
    logic [6:0] message_length;
  } out_item_t;

  // Command from the parser to the unmask stage.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
    logic [6:0] len;
  } cmd_t;

  // Queue status seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

/* rtl/wsfu_front.sv */
// Header parser and key capture; turns close, empty and payload bytes into commands.
`timescale 1ns / 1ps
`default_nettype none
module wsfu_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wsfu_pkg::in_item_t    item,
  output logic                  cmd_valid,
  output wsfu_pkg::cmd_t        cmd
);
  import wsfu_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [6:0]  count_r, count_nxt;
  logic [1:0]  key_idx_r, key_idx_nxt;
  logic [7:0]  key_r [4];
  logic [6:0]  count_inc;

  assign count_inc = count_r + 7'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      opcode_r  <= '0;
      masked_r  <= 1'b0;
      len_r     <= '0;
      count_r   <= '0;
      key_idx_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      opcode_r  <= opcode_nxt;
      masked_r  <= masked_nxt;
      len_r     <= len_nxt;
      count_r   <= count_nxt;
      key_idx_r <= key_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase_r == PH_KEY) begin
      key_r[key_idx_r] <= item.rx_byte;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    opcode_nxt  = opcode_r;
    masked_nxt  = masked_r;
    len_nxt     = len_r;
    count_nxt   = count_r;
    key_idx_nxt = key_idx_r;
    cmd_valid   = 1'b0;
    cmd         = '0;
    if (accept) begin
      case (phase_r)
        PH_HDR0: begin
          opcode_nxt = item.rx_byte[3:0];
          if (item.rx_byte[3:0] == OPC_CLOSE) begin
            cmd_valid = 1'b1;
            cmd.kind  = KIND_CLOSE;
            cmd.last  = 1'b1;
            phase_nxt = PH_DROP;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_HDR1: begin
          masked_nxt = item.rx_byte[7];
          len_nxt    = item.rx_byte[6:0];
          if (item.rx_byte[6:0] > LEN_MAX || opcode_r != OPC_TEXT) begin
            phase_nxt = PH_DROP;
          end else if (item.rx_byte[6:0] == 7'd0) begin
            cmd_valid = 1'b1;
            cmd.kind  = KIND_EMPTY;
            cmd.last  = 1'b1;
            phase_nxt = PH_DROP;
          end else if (item.rx_byte[7]) begin
            key_idx_nxt = '0;
            phase_nxt   = PH_KEY;
          end else begin
            count_nxt = '0;
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_KEY: begin
          key_idx_nxt = key_idx_r + 2'd1;
          if (key_idx_r == 2'd3) begin
            count_nxt = '0;
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          cmd_valid = 1'b1;
          cmd.kind  = KIND_PAYLOAD;
          cmd.data  = item.rx_byte;
          cmd.key   = masked_r ? key_r[count_r[1:0]] : 8'h00;
          cmd.last  = (count_inc == len_r);
          cmd.len   = len_r;
          count_nxt = count_inc;
          if (count_inc == len_r) begin
            phase_nxt = PH_DROP;
          end
        end
        default: begin
          // drop phase: swallow bytes until the buffer ends
        end
      endcase
      if (item.buffer_end) begin
        phase_nxt = PH_HDR0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/wsfu_fifo.sv */
// Short command queue between parser and unmask stage.
`timescale 1ns / 1ps
`default_nettype none
module wsfu_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wsfu_pkg::cmd_t         wr_data,
  input  wire logic              rd_en,
  output wsfu_pkg::cmd_t         rd_data,
  output wsfu_pkg::q_status_t    status
);
  import wsfu_pkg::*;

  cmd_t                 slot_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] count_r, count_nxt;
  logic                 do_wr, do_rd;

  assign status.full  = (count_r == CMD_CNT_W'(CMD_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_wr        = wr_en && !status.full;
  assign do_rd        = rd_en && !status.empty;
  assign rd_data      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? CMD_PTR_W'((wr_ptr_r + 1'b1) % CMD_DEPTH) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? CMD_PTR_W'((rd_ptr_r + 1'b1) % CMD_DEPTH) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/wsfu_back.sv */
// Unmask stage: XORs payload with key and holds the result register.
`timescale 1ns / 1ps
`default_nettype none
module wsfu_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wsfu_pkg::q_status_t   q_status,
  input  wsfu_pkg::cmd_t        q_data,
  output logic                  q_rd,
  input  wire logic             out_pop,
  output logic                  out_empty,
  output wsfu_pkg::out_item_t   out_data
);
  import wsfu_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t data_r, data_nxt;

  assign q_rd = !q_status.empty && (!valid_r || out_pop);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (valid_r && out_pop) begin
      valid_nxt = 1'b0;
    end
    if (q_rd) begin
      valid_nxt                = 1'b1;
      data_nxt.kind            = q_data.kind;
      data_nxt.payload_byte    = q_data.data ^ q_data.key;
      data_nxt.last_of_message = q_data.last;
      data_nxt.message_length  = q_data.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_empty = !valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

/* rtl/websocket_frame_unmasker.sv */
// Top level of the websocket frame receiver and unmasker.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------
//  in_     | input     | in_push / in_full | rx_byte, buffer_end
//  out_    | output    | out_empty/out_pop | kind, payload_byte, last, length
//
// One byte per cycle, sustained: the parser takes a byte every cycle while
// the command queue has room. A result passes through the command queue
// and then the unmask register before it shows on out_; a stalled out_
// side holds it back in the queue.
// Synchronous active-low reset clears parser phase, queue and result valid;
// the four key bytes are not reset and are always written before use.
// in_full rises only when the four-deep command queue is full, i.e. when the
// out_ side has stalled.
`timescale 1ns / 1ps
`default_nettype none
module websocket_frame_unmasker (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wsfu_pkg::in_item_t    in_data,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output wsfu_pkg::out_item_t   out_data
);
  import wsfu_pkg::*;

  logic      accept;
  logic      cmd_valid;
  cmd_t      cmd;
  cmd_t      q_data;
  logic      q_rd;
  q_status_t q_status;

  // Any accepted byte may produce a command, so gate on queue space.
  assign in_full = q_status.full;
  assign accept  = in_push && !q_status.full;

  // Front: header decode, key capture, payload classification.
  wsfu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // Decoupling queue: lets the parser run while the result side stalls.
  wsfu_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .status  (q_status)
  );

  // Back: unmask XOR and registered result.
  wsfu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_data    (q_data),
    .q_rd      (q_rd),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* rtl/wsfu_checker.sv */
// Port-level checker for the frame unmasker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_unmasker_assert.svh"
module wsfu_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_full,
  input wire logic             out_empty,
  input wire logic             out_pop,
  input wsfu_pkg::out_item_t   out_data
);
  import wsfu_pkg::*;

  `WSFU_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_data))
  `WSFU_ASSERT_IMPL(a_kind_legal, !out_empty, out_data.kind != 2'd3)
  `WSFU_ASSERT_IMPL(a_ctrl_result, !out_empty && out_data.kind != KIND_PAYLOAD, out_data.last_of_message && out_data.message_length == 7'd0 && out_data.payload_byte == 8'h00)
  `WSFU_ASSERT_IMPL(a_payload_len, !out_empty && out_data.kind == KIND_PAYLOAD, out_data.message_length != 7'd0 && out_data.message_length <= LEN_MAX)
  // A full queue means a result is already waiting in the output register.
  `WSFU_ASSERT_IMPL(a_full_has_result, in_full, !out_empty)

endmodule

bind websocket_frame_unmasker wsfu_checker u_wsfu_checker (.*);
`default_nettype wire

/* sim/tb_websocket_frame_unmasker.sv */
// Self-checking testbench for the websocket frame receiver and unmasker.
`timescale 1ns / 1ps
module tb_websocket_frame_unmasker;
  import wsfu_pkg::*;

  // Stop generating random buffers once this many bytes went in.
  localparam int BYTE_TARGET  = 1750;
  // Results trail their bytes through the queue and result register; give the tail some slack.
  localparam int DRAIN_CYCLES = 12;
  // Keep the log short if the block is badly broken; counting goes on.
  localparam int PRINT_CAP    = 50;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_push  = 1'b0;
  logic      in_full;
  in_item_t  in_data  = '0;
  logic      out_empty;
  logic      out_pop  = 1'b0;
  out_item_t out_data;

  websocket_frame_unmasker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  // Mirror of the frame parser. Each accepted byte advances the mirror; any
  // result the byte causes is queued in results_due, oldest first, and every
  // popped transaction is matched against the head of that queue.
  class ws_rx_mirror;
    phase_t      ph;
    logic [3:0]  opcode;
    logic        masked;
    logic [6:0]  decl_len;
    logic [6:0]  pay_cnt;
    logic [7:0]  key [4];
    logic [1:0]  key_idx;
    out_item_t   results_due[$];
    int unsigned mismatch_count;
    int unsigned payload_seen;
    int unsigned close_seen;
    int unsigned empty_seen;

    function new();
      ph       = PH_HDR0;
      opcode   = '0;
      masked   = 1'b0;
      decl_len = '0;
      pay_cnt  = '0;
      key_idx  = '0;
      foreach (key[i]) key[i] = '0;
    endfunction

    task flag_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP) begin
        $display("%0t ERROR: %s", $realtime, msg);
      end
      mismatch_count++;
    endtask

    function void take_byte(input in_item_t it);
      out_item_t  r;
      bit         emit;
      logic [7:0] k;
      r    = '0;
      emit = 1'b0;
      case (ph)
        PH_HDR0: begin
          opcode = it.rx_byte[3:0];
          // Close answers at once; the rest of the buffer is ignored.
          if (opcode == OPC_CLOSE) begin
            r.kind            = KIND_CLOSE;
            r.last_of_message = 1'b1;
            emit              = 1'b1;
            ph                = PH_DROP;
          end else begin
            ph = PH_HDR1;
          end
        end
        PH_HDR1: begin
          masked   = it.rx_byte[7];
          decl_len = it.rx_byte[6:0];
          if (decl_len > LEN_MAX || opcode != OPC_TEXT) begin
            ph = PH_DROP;
          end else if (decl_len == 0) begin
            // Empty text message: any key bytes that follow are dropped.
            r.kind            = KIND_EMPTY;
            r.last_of_message = 1'b1;
            emit              = 1'b1;
            ph                = PH_DROP;
          end else if (masked) begin
            key_idx = '0;
            ph      = PH_KEY;
          end else begin
            pay_cnt = '0;
            ph      = PH_PAYLOAD;
          end
        end
        PH_KEY: begin
          key[key_idx] = it.rx_byte;
          key_idx      = key_idx + 2'd1;
          if (key_idx == 0) begin
            pay_cnt = '0;
            ph      = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          k                 = masked ? key[pay_cnt[1:0]] : 8'h00;
          pay_cnt           = pay_cnt + 7'd1;
          r.kind            = KIND_PAYLOAD;
          r.payload_byte    = it.rx_byte ^ k;
          r.last_of_message = (pay_cnt == decl_len);
          r.message_length  = decl_len;
          emit              = 1'b1;
          if (r.last_of_message) ph = PH_DROP;
        end
        default: ;
      endcase
      // End of buffer always restarts the parser, even mid-frame.
      if (it.buffer_end) ph = PH_HDR0;
      if (emit) results_due.push_back(r);
    endfunction

    task match_result(input out_item_t got);
      out_item_t want;
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind=%0d byte=%02h last=%0b len=%0d",
                                got.kind, got.payload_byte, got.last_of_message,
                                got.message_length));
      end else begin
        want = results_due.pop_front();
        case (want.kind)
          KIND_PAYLOAD: payload_seen++;
          KIND_CLOSE:   close_seen++;
          default:      empty_seen++;
        endcase
        if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
            got.last_of_message !== want.last_of_message ||
            got.message_length !== want.message_length) begin
          flag_mismatch($sformatf({"kind %0d/%0d byte %02h/%02h last %0b/%0b len %0d/%0d",
                                   " (got/want)"},
                                  got.kind, want.kind, got.payload_byte, want.payload_byte,
                                  got.last_of_message, want.last_of_message,
                                  got.message_length, want.message_length));
        end
      end
    endtask
  endclass

  ws_rx_mirror tracker = new();
  int unsigned bytes_sent;
  int unsigned buffers_sent;

  always #2 clk = ~clk;

  // Idle length for either side: mostly none or short, now and then a
  // long one so the four-deep command queue fills and in_full kicks in.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // One input transaction. Data changes on the falling edge; acceptance is
  // judged on the rising edge from in_full as it stood before the edge.
  task automatic push_byte(input logic [7:0] b, input logic fin, input bit steady);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= '{rx_byte: b, buffer_end: fin};
    do @(posedge clk); while (in_full);
    tracker.take_byte(in_data);
    bytes_sent++;
  endtask

  // Push a whole buffer, marking its last byte. About a third of the buffers
  // go back to back with no input idling at all.
  task automatic send_buffer(input logic [7:0] frame_q[$]);
    bit steady;
    steady = ($urandom_range(0, 9) < 3);
    foreach (frame_q[i]) push_byte(frame_q[i], i == frame_q.size() - 1, steady);
    buffers_sent++;
  endtask

  // Mostly well-formed frames with random content, biased toward text so the
  // key and payload phases get most of the traffic. A few buffers are pure
  // noise, some carry trailing bytes, and some are cut short anywhere.
  task automatic random_buffer();
    logic [7:0]  frame_q[$];
    int unsigned sel;
    int unsigned len;
    int unsigned cut;
    logic [3:0]  opc;
    bit          masked;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (sel < 75) opc = OPC_TEXT;
      else if (sel < 83) opc = OPC_CLOSE;
      else opc = 4'($urandom_range(0, 15));
      sel = $urandom_range(0, 199);
      if (sel < 16) len = 0;
      else if (sel < 186) len = $urandom_range(1, 12);
      else if (sel < 192) len = $urandom_range(13, 124);
      else if (sel < 195) len = LEN_MAX;
      else len = $urandom_range(126, 127);
      masked = $urandom_range(0, 1);
      // High nibble of the first byte (FIN and reserved bits) is don't-care.
      frame_q.push_back({4'($urandom_range(0, 15)), opc});
      frame_q.push_back({masked, 7'(len)});
      if (masked) repeat (4) frame_q.push_back(8'($urandom_range(0, 255)));
      repeat ((len > LEN_MAX) ? 3 : len) frame_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) begin
        cut     = $urandom_range(1, frame_q.size());
        frame_q = frame_q[0:cut-1];
      end
    end
    send_buffer(frame_q);
  endtask

  // Result side: runs of pops broken by stalls of random length.
  initial begin
    int unsigned run;
    int unsigned stall;
    wait (rst_n);
    forever begin
      run = $urandom_range(1, 40);
      @(negedge clk);
      out_pop <= 1'b1;
      repeat (run - 1) @(negedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        @(negedge clk);
        out_pop <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // Every popped transaction is checked against the mirror.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) tracker.match_result(out_data);
  end

  initial begin
    logic [7:0] frame_q[$];
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames first.
    // Close with nothing after it.
    frame_q = '{8'h88};
    send_buffer(frame_q);
    // Close with FIN clear and a trailing byte that must be dropped.
    frame_q = '{8'h08, 8'hFF};
    send_buffer(frame_q);
    // Binary frame: no result at all.
    frame_q = '{8'h82, 8'h81, 8'hAA};
    send_buffer(frame_q);
    // Extended lengths are not supported: 126 unmasked, 127 masked.
    frame_q = '{8'h81, 8'h7E, 8'h00};
    send_buffer(frame_q);
    frame_q = '{8'h81, 8'hFF};
    send_buffer(frame_q);
    // Zero-length masked text: empty result, key bytes dropped.
    frame_q = '{8'h81, 8'h80, 8'h11};
    send_buffer(frame_q);
    // Unmasked one-byte text plus a byte beyond the frame.
    frame_q = '{8'h01, 8'h01, 8'h5A, 8'h33};
    send_buffer(frame_q);
    // Masked two-byte text with extreme key and payload values.
    frame_q = '{8'h81, 8'h82, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'h00};
    send_buffer(frame_q);
    // Buffer cut after the first header byte.
    frame_q = '{8'h81};
    send_buffer(frame_q);

    while (bytes_sent < BYTE_TARGET) random_buffer();

    @(negedge clk);
    in_push <= 1'b0;
    while (tracker.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d buffers under random idling on both sides.",
             bytes_sent, buffers_sent);
    $display("Checked %0d payload, %0d close and %0d empty-message results; %0d mismatches.",
             tracker.payload_seen, tracker.close_seen, tracker.empty_seen,
             tracker.mismatch_count);
    if (tracker.mismatch_count == 0 && tracker.results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog. A normal run ends well before this timeout even with every
  // byte hitting a long stall.
  initial begin
    #4_000_000;
    $display("Timed out with %0d results still due.", tracker.results_due.size());
    $display("FAIL");
    $finish;
  end

endmodule
